[sv/traffic_light_mode_controller_assert.svh]
// Assertion macros for the checker file of the traffic light controller.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef TRAFFIC_LIGHT_MODE_CONTROLLER_ASSERT_SVH
`define TRAFFIC_LIGHT_MODE_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tlmc_pkg.sv]
package tlmc_pkg;

    // Tick rate and field widths.
    localparam int TICKS_PER_SECOND = 10;
    localparam int TICK_W           = 4;
    localparam int SEC_W            = 8;
    localparam int CFG_W            = 8;
    localparam int CFG_IDX_W        = 3;
    localparam int MODE_W           = 3;
    localparam int LAMP_W           = 5;

    // Controller modes, as shown on current_mode.
    localparam logic [MODE_W-1:0] MODE_RED       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GREEN     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WARN      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WALK      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PRIORITY  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_BLINK_ON  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BLINK_OFF = 3'd6;
    localparam logic [MODE_W-1:0] MODE_DEBOUNCE  = 3'd7;

    // Lamp vector bits.
    localparam logic [LAMP_W-1:0] LAMP_NONE = 5'b00000;
    localparam logic [LAMP_W-1:0] LAMP_RR   = 5'b00001;
    localparam logic [LAMP_W-1:0] LAMP_RY   = 5'b00010;
    localparam logic [LAMP_W-1:0] LAMP_RG   = 5'b00100;
    localparam logic [LAMP_W-1:0] LAMP_WR   = 5'b01000;
    localparam logic [LAMP_W-1:0] LAMP_WG   = 5'b10000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RED_PHASE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_PHASE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSSING_WARN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSSING_WALK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_GREEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_DEBOUNCE  = 3'd6;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TICK_W-1:0] tick;
        logic [SEC_W-1:0]  second;
        logic              prio_pend;
        logic              cross_pend;
        logic              serv_pend;
        logic [LAMP_W-1:0] lamp;
    } ctrl_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] red_phase;
        logic [CFG_W-1:0] green_phase;
        logic [CFG_W-1:0] crossing_warn;
        logic [CFG_W-1:0] crossing_walk;
        logic [CFG_W-1:0] priority_green;
        logic [CFG_W-1:0] blink_half;
        logic [CFG_W-1:0] exit_debounce;
    } ctrl_cfg_t;

    typedef struct packed {
        logic priority_press;
        logic crossing_press;
        logic service_press;
        logic service_button_down;
    } tick_req_t;

    localparam ctrl_state_t STATE_RESET = '{
        mode:       MODE_RED,
        tick:       '0,
        second:     '0,
        prio_pend:  1'b0,
        cross_pend: 1'b0,
        serv_pend:  1'b0,
        lamp:       LAMP_RR | LAMP_WG
    };

    localparam ctrl_cfg_t CFG_RESET = '{
        red_phase:      8'd5,
        green_phase:    8'd5,
        crossing_warn:  8'd5,
        crossing_walk:  8'd10,
        priority_green: 8'd10,
        blink_half:     8'd5,
        exit_debounce:  8'd2
    };

endpackage

[sv/tlmc_step.sv]
module tlmc_step
    import tlmc_pkg::*;
(
    input  ctrl_state_t cur,
    input  ctrl_cfg_t   cfg,
    input  tick_req_t   req,
    output ctrl_state_t nxt
);

    // Where the request order starts at a decision point.
    localparam logic [1:0] DEC_FULL  = 2'd0;
    localparam logic [1:0] DEC_PRIO  = 2'd1;
    localparam logic [1:0] DEC_CROSS = 2'd2;
    localparam logic [1:0] DEC_RED   = 2'd3;

    logic              maint;
    logic              any_pend;
    logic              sec_tick;
    logic [TICK_W-1:0] tick_inc;
    logic [SEC_W-1:0]  sec_sat;
    logic [SEC_W-1:0]  sec_now;
    logic              do_decide;
    logic [1:0]        level;
    logic              do_enter;
    logic [MODE_W-1:0] ent_mode;
    logic [LAMP_W-1:0] ent_lamp;

    always_comb
    begin
        maint = cur.mode inside {MODE_BLINK_ON, MODE_BLINK_OFF, MODE_DEBOUNCE};

        // Latch new requests first; maintenance presses are ignored in the blink and debounce modes.
        nxt            = cur;
        nxt.prio_pend  = cur.prio_pend | req.priority_press;
        nxt.cross_pend = cur.cross_pend | req.crossing_press;
        nxt.serv_pend  = cur.serv_pend | (req.service_press & ~maint);
        any_pend       = nxt.prio_pend | nxt.cross_pend | nxt.serv_pend;

        // Count the tick: seconds in the timed modes, raw ticks in maintenance.
        tick_inc = cur.tick + 1'b1;
        sec_sat  = (cur.second == '1) ? cur.second : cur.second + 1'b1;
        sec_tick = tick_inc >= TICK_W'(TICKS_PER_SECOND);
        if (maint)
        begin
            nxt.second = sec_sat;
        end
        else
        begin
            nxt.tick   = sec_tick ? '0 : tick_inc;
            nxt.second = sec_tick ? sec_sat : cur.second;
        end
        sec_now = nxt.second;

        // Pick the transition for the current mode.
        do_decide = 1'b0;
        level     = DEC_FULL;
        do_enter  = 1'b0;
        ent_mode  = MODE_RED;
        ent_lamp  = LAMP_RR | LAMP_WG;
        case (cur.mode)
            MODE_RED:
            begin
                if (sec_tick && any_pend)
                begin
                    do_decide = 1'b1;
                end
                else if (sec_tick && sec_now >= cfg.red_phase)
                begin
                    do_enter = 1'b1;
                    ent_mode = MODE_GREEN;
                    ent_lamp = LAMP_RG | LAMP_WR;
                end
            end
            MODE_GREEN:
            begin
                if (sec_tick && (any_pend || sec_now >= cfg.green_phase))
                begin
                    do_decide = 1'b1;
                end
            end
            MODE_WARN:
            begin
                if (sec_tick && sec_now >= cfg.crossing_warn)
                begin
                    do_enter = 1'b1;
                    ent_mode = MODE_WALK;
                    ent_lamp = LAMP_RR | LAMP_WG;
                end
            end
            MODE_WALK:
            begin
                if (sec_tick && sec_now >= cfg.crossing_walk)
                begin
                    do_decide = 1'b1;
                    level     = DEC_RED;
                end
            end
            MODE_PRIORITY:
            begin
                if (sec_tick && sec_now >= cfg.priority_green)
                begin
                    do_decide = 1'b1;
                    level     = DEC_CROSS;
                end
            end
            MODE_BLINK_ON:
            begin
                if (sec_now >= cfg.blink_half)
                begin
                    do_enter = 1'b1;
                    ent_mode = MODE_BLINK_OFF;
                    ent_lamp = LAMP_NONE;
                end
            end
            MODE_BLINK_OFF:
            begin
                if (sec_now >= cfg.blink_half)
                begin
                    do_enter = 1'b1;
                    ent_mode = req.service_button_down ? MODE_DEBOUNCE : MODE_BLINK_ON;
                    ent_lamp = req.service_button_down ? LAMP_NONE : LAMP_RY;
                end
            end
            default:
            begin
                // Debounce: a button still held ends maintenance.
                if (sec_now >= cfg.exit_debounce)
                begin
                    if (req.service_button_down)
                    begin
                        nxt.serv_pend = 1'b0;
                        do_decide     = 1'b1;
                        level         = DEC_PRIO;
                    end
                    else
                    begin
                        do_enter = 1'b1;
                        ent_mode = MODE_BLINK_ON;
                        ent_lamp = LAMP_RY;
                    end
                end
            end
        endcase

        // Serve pending requests in order from the chosen starting point.
        if (do_decide)
        begin
            do_enter = 1'b1;
            if (level == DEC_FULL && nxt.serv_pend)
            begin
                ent_mode = MODE_BLINK_ON;
                ent_lamp = LAMP_RY;
            end
            else if (level <= DEC_PRIO && nxt.prio_pend)
            begin
                nxt.prio_pend = 1'b0;
                ent_mode      = MODE_PRIORITY;
                ent_lamp      = LAMP_RG | LAMP_WR;
            end
            else if (level <= DEC_CROSS && nxt.cross_pend)
            begin
                nxt.cross_pend = 1'b0;
                ent_mode       = MODE_WARN;
                ent_lamp       = cur.lamp | LAMP_RY;
            end
            else
            begin
                ent_mode = MODE_RED;
                ent_lamp = LAMP_RR | LAMP_WG;
            end
        end

        // Entering a mode restarts both counters.
        if (do_enter)
        begin
            nxt.mode   = ent_mode;
            nxt.lamp   = ent_lamp;
            nxt.tick   = '0;
            nxt.second = '0;
        end
    end

endmodule

[sv/traffic_light_mode_controller.sv]
// Road and pedestrian light controller stepped by one 100 ms tick per input request.
// Each accepted request is one tick and yields exactly one result request showing the
// lamps and mode after that tick. The whole step is one
// pass of logic from the state register back into itself, and that state register
// drives the result ports, so a new tick is accepted in every cycle in which the
// previous result is taken (or none is waiting). Configuration writes land on the
// next clock edge and are meant to be made while no result is outstanding.
module traffic_light_mode_controller
    import tlmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Tick requests.
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 priority_press,
    input  logic                 crossing_press,
    input  logic                 service_press,
    input  logic                 service_button_down,
    // Lamp results.
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 road_red_lamp,
    output logic                 road_yellow_lamp,
    output logic                 road_green_lamp,
    output logic                 walker_red_lamp,
    output logic                 walker_green_lamp,
    output logic [MODE_W-1:0]    current_mode,
    // Configuration writes.
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    ctrl_state_t step_state;
    ctrl_cfg_t   cfg_reg;
    ctrl_cfg_t   cfg_next;
    tick_req_t   req;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        accept;

    assign req = '{
        priority_press:      priority_press,
        crossing_press:      crossing_press,
        service_press:       service_press,
        service_button_down: service_button_down
    };

    tlmc_step u_step (
        .cur (state_reg),
        .cfg (cfg_reg),
        .req (req),
        .nxt (step_state)
    );

    // Handshake: the state register doubles as the result register.
    assign in_ready       = ~out_valid_reg | out_ready;
    assign accept         = in_valid & in_ready;
    assign state_next     = accept ? step_state : state_reg;
    assign out_valid_next = accept | (out_valid_reg & ~out_ready);

    // Configuration register writes; unused indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_RED_PHASE:      cfg_next.red_phase      = cfg_data;
                CFG_GREEN_PHASE:    cfg_next.green_phase    = cfg_data;
                CFG_CROSSING_WARN:  cfg_next.crossing_warn  = cfg_data;
                CFG_CROSSING_WALK:  cfg_next.crossing_walk  = cfg_data;
                CFG_PRIORITY_GREEN: cfg_next.priority_green = cfg_data;
                CFG_BLINK_HALF:     cfg_next.blink_half     = cfg_data;
                CFG_EXIT_DEBOUNCE:  cfg_next.exit_debounce  = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            cfg_reg       <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result ports.
    assign out_valid         = out_valid_reg;
    assign road_red_lamp     = state_reg.lamp[0];
    assign road_yellow_lamp  = state_reg.lamp[1];
    assign road_green_lamp   = state_reg.lamp[2];
    assign walker_red_lamp   = state_reg.lamp[3];
    assign walker_green_lamp = state_reg.lamp[4];
    assign current_mode      = state_reg.mode;

endmodule

[sv/tlmc_checker.sv]
`include "traffic_light_mode_controller_assert.svh"

module tlmc_checker
    import tlmc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              road_red_lamp,
    input logic              road_yellow_lamp,
    input logic              road_green_lamp,
    input logic              walker_red_lamp,
    input logic              walker_green_lamp,
    input logic [MODE_W-1:0] current_mode
);

    logic [LAMP_W-1:0]        lamps;
    logic [LAMP_W+MODE_W-1:0] shown;
    logic                     stalled;
    logic                     in_green;
    logic                     green_ok;
    logic                     in_dark;

    // Lamp outputs gathered in the order of the lamp vector bits.
    assign lamps    = {walker_green_lamp, walker_red_lamp, road_green_lamp,
                       road_yellow_lamp, road_red_lamp};
    assign shown    = {lamps, current_mode};
    assign stalled  = out_valid && !out_ready;
    assign in_green = out_valid && (current_mode == MODE_GREEN);
    assign green_ok = (lamps == (LAMP_RG | LAMP_WR));
    assign in_dark  = out_valid &&
                      (current_mode == MODE_BLINK_OFF || current_mode == MODE_DEBOUNCE);

    // A stalled result keeps its mode and lamps.
    `TLMC_ASSERT_NEXT(a_hold, stalled, out_valid && $stable(shown), "stalled result changed")

    // Every accepted tick yields a result in the next cycle.
    `TLMC_ASSERT_NEXT(a_accept_result, in_valid && in_ready, out_valid, "tick gave no result")

    // With no result waiting the block must take a tick.
    `TLMC_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "stalled while empty")

    // Normal green shows only road green and walker red.
    `TLMC_ASSERT_NOW(a_green_lamps, in_green, green_ok, "wrong lamps in green phase")

    // The dark half of the blink and the debounce show no lamp at all.
    `TLMC_ASSERT_NOW(a_dark_lamps, in_dark, lamps == LAMP_NONE, "lamp lit while dark")

endmodule

bind traffic_light_mode_controller tlmc_checker u_tlmc_checker (.*);
